[src/soa_pkg.sv]
`default_nettype none
package soa_pkg;

    localparam int NUM_PAGES = 16;
    localparam int MAX_SLOTS = 64;
    localparam int PAGE_W    = 4;
    localparam int SLOT_W    = 6;
    localparam int ENTRY_W   = PAGE_W + SLOT_W;
    localparam int LINK_W    = ENTRY_W + 1;
    localparam int CNT_W     = 7;
    localparam int PLINK_W   = PAGE_W + 1;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;
    localparam logic       ST_OK    = 1'b0;
    localparam logic       ST_OOM   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [PAGE_W-1:0] free_page;
        logic [SLOT_W-1:0] free_slot;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] obj_page;
        logic [SLOT_W-1:0] obj_slot;
        logic [CNT_W-1:0]  page_in_use;
    } rsp_t;

    // One page record: own free list head, in-use count, next partial page
    typedef struct packed {
        logic [LINK_W-1:0]  head;
        logic [CNT_W-1:0]   count;
        logic [PLINK_W-1:0] plink;
    } page_ent_t;

endpackage
`default_nettype wire

[src/soa_slot_mem.sv]
`default_nettype none
module soa_slot_mem
    import soa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ENTRY_W-1:0] waddr,
    input  wire logic [LINK_W-1:0]  wdata,
    input  wire logic [ENTRY_W-1:0] raddr,
    output logic      [LINK_W-1:0]  rdata
);

    logic [LINK_W-1:0] mem [NUM_PAGES*MAX_SLOTS];

    // Write the link, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/soa_page_mem.sv]
`default_nettype none
module soa_page_mem
    import soa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [PAGE_W-1:0] waddr,
    input  wire page_ent_t         wdata,
    input  wire logic [PAGE_W-1:0] raddr,
    output page_ent_t              rdata
);

    page_ent_t mem [NUM_PAGES];

    // Write the page record, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/soa_ctrl.sv]
`default_nettype none
module soa_ctrl
    import soa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire req_t               req,
    output logic                    done,
    output rsp_t                    rsp,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   cfg_data,
    output logic                    slot_we,
    output logic      [ENTRY_W-1:0] slot_waddr,
    output logic      [LINK_W-1:0]  slot_wdata,
    output logic      [ENTRY_W-1:0] slot_raddr,
    input  wire logic [LINK_W-1:0]  slot_rdata,
    output logic                    page_we,
    output logic      [PAGE_W-1:0]  page_waddr,
    output page_ent_t               page_wdata,
    output logic      [PAGE_W-1:0]  page_raddr,
    input  wire page_ent_t          page_rdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_POP_RD, S_POP, S_PART, S_FILL, S_FREE
    } state_t;

    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    active_head_reg, active_head_next;
    logic [PLINK_W-1:0]   active_page_reg, active_page_next;
    logic [PLINK_W-1:0]   partial_head_reg, partial_head_next;
    logic [PLINK_W-1:0]   claimed_reg, claimed_next;
    logic [CNT_W-1:0]     opp_reg, opp_next;
    logic [CNT_W-1:0]     fill_n_reg, fill_n_next;
    logic [SLOT_W-1:0]    fill_i_reg, fill_i_next;
    logic [PAGE_W-1:0]    op_page_reg, op_page_next;
    logic [SLOT_W-1:0]    op_slot_reg, op_slot_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 accept;
    logic [ENTRY_W-1:0]   pop_entry;
    logic [PLINK_W-1:0]   part_page;
    logic [CNT_W-1:0]     clamp_n;
    logic [ENTRY_W-1:0]   fill_entry;
    logic [ENTRY_W-1:0]   free_entry;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     cnt_dec;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign pop_entry  = ENTRY_W'(active_head_reg - LINK_W'(1));
    assign part_page  = partial_head_reg - PLINK_W'(1);
    assign fill_entry = {claimed_reg[PAGE_W-1:0], fill_i_reg};
    assign free_entry = {op_page_reg, op_slot_reg};
    assign cnt_inc    = (page_rdata.count == {CNT_W{1'b1}}) ? page_rdata.count
                                                            : page_rdata.count + CNT_W'(1);
    assign cnt_dec    = (page_rdata.count == '0) ? '0 : page_rdata.count - CNT_W'(1);

    // Clamp slots per fresh page to one..MAX_SLOTS
    always_comb
    begin
        if (opp_reg == '0)
        begin
            clamp_n = CNT_W'(1);
        end
        else if (opp_reg > CNT_W'(MAX_SLOTS))
        begin
            clamp_n = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            clamp_n = opp_reg;
        end
    end

    // Read at the active head; idle frees and empty-list allocs read other pages
    always_comb
    begin
        slot_raddr = pop_entry;
        page_raddr = pop_entry[ENTRY_W-1:SLOT_W];
        if (state_reg == S_IDLE)
        begin
            if (req.opcode == OP_FREE)
            begin
                page_raddr = req.free_page;
            end
            else if (active_head_reg == '0)
            begin
                page_raddr = part_page[PAGE_W-1:0];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        active_head_next  = active_head_reg;
        active_page_next  = active_page_reg;
        partial_head_next = partial_head_reg;
        claimed_next      = claimed_reg;
        opp_next          = opp_reg;
        fill_n_next       = fill_n_reg;
        fill_i_next       = fill_i_reg;
        op_page_next      = op_page_reg;
        op_slot_next      = op_slot_reg;
        done_next         = 1'b0;
        rsp_next          = rsp_reg;
        slot_we           = 1'b0;
        slot_waddr        = free_entry;
        slot_wdata        = active_head_reg;
        page_we           = 1'b0;
        page_waddr        = op_page_reg;
        page_wdata        = page_rdata;

        if (cfg_valid)
        begin
            opp_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_page_next = req.free_page;
                    op_slot_next = req.free_slot;
                    if (req.opcode == OP_FREE)
                    begin
                        if ({1'b0, req.free_page} >= claimed_reg)
                        begin
                            // Drop a free of an unclaimed page, echo the object
                            done_next = 1'b1;
                            rsp_next  = '{ST_OK, req.free_page, req.free_slot, '0};
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else if (active_head_reg != '0)
                    begin
                        state_next = S_POP;
                    end
                    else if (partial_head_reg != '0)
                    begin
                        op_page_next = part_page[PAGE_W-1:0];
                        state_next   = S_PART;
                    end
                    else if (claimed_reg < PLINK_W'(NUM_PAGES))
                    begin
                        fill_n_next = clamp_n;
                        fill_i_next = '0;
                        state_next  = S_FILL;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{ST_OOM, '0, '0, '0};
                    end
                end
            end

            S_PART:
            begin
                if (page_rdata.head == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OOM, '0, '0, '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    // Make the partial page active and unlink it
                    partial_head_next = page_rdata.plink;
                    active_head_next  = page_rdata.head;
                    active_page_next  = {1'b0, op_page_reg} + PLINK_W'(1);
                    page_we           = 1'b1;
                    page_wdata        = '{'0, page_rdata.count, '0};
                    state_next        = S_POP_RD;
                end
            end

            S_FILL:
            begin
                // Chain one slot of the fresh page per cycle
                slot_we    = 1'b1;
                slot_waddr = fill_entry;
                if ({1'b0, fill_i_reg} + CNT_W'(1) < fill_n_reg)
                begin
                    slot_wdata  = {1'b0, fill_entry} + LINK_W'(2);
                    fill_i_next = fill_i_reg + SLOT_W'(1);
                end
                else
                begin
                    slot_wdata       = '0;
                    page_we          = 1'b1;
                    page_waddr       = claimed_reg[PAGE_W-1:0];
                    page_wdata       = '{'0, '0, '0};
                    active_head_next = {1'b0, claimed_reg[PAGE_W-1:0], {SLOT_W{1'b0}}}
                                       + LINK_W'(1);
                    active_page_next = claimed_reg + PLINK_W'(1);
                    claimed_next     = claimed_reg + PLINK_W'(1);
                    state_next       = S_POP_RD;
                end
            end

            S_POP_RD:
            begin
                state_next = S_POP;
            end

            S_POP:
            begin
                // Pop the active head and count it in
                active_head_next = slot_rdata;
                page_we          = 1'b1;
                page_waddr       = pop_entry[ENTRY_W-1:SLOT_W];
                page_wdata       = '{page_rdata.head, cnt_inc, page_rdata.plink};
                done_next        = 1'b1;
                rsp_next         = '{ST_OK, pop_entry[ENTRY_W-1:SLOT_W],
                                     pop_entry[SLOT_W-1:0], cnt_inc};
                state_next       = S_IDLE;
            end

            S_FREE:
            begin
                slot_we    = 1'b1;
                page_we    = 1'b1;
                page_wdata = '{page_rdata.head, cnt_dec, page_rdata.plink};
                if (active_page_reg == {1'b0, op_page_reg} + PLINK_W'(1))
                begin
                    slot_wdata       = active_head_reg;
                    active_head_next = {1'b0, free_entry} + LINK_W'(1);
                end
                else
                begin
                    slot_wdata      = page_rdata.head;
                    page_wdata.head = {1'b0, free_entry} + LINK_W'(1);
                    if (page_rdata.head == '0)
                    begin
                        // A full page joins the partial list
                        page_wdata.plink  = partial_head_reg;
                        partial_head_next = {1'b0, op_page_reg} + PLINK_W'(1);
                    end
                end
                done_next  = 1'b1;
                rsp_next   = '{ST_OK, op_page_reg, op_slot_reg, cnt_dec};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_head_reg  <= '0;
            active_page_reg  <= '0;
            partial_head_reg <= '0;
            claimed_reg      <= '0;
            opp_reg          <= CNT_W'(MAX_SLOTS);
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_head_reg  <= active_head_next;
            active_page_reg  <= active_page_next;
            partial_head_reg <= partial_head_next;
            claimed_reg      <= claimed_next;
            opp_reg          <= opp_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_n_reg  <= fill_n_next;
        fill_i_reg  <= fill_i_next;
        op_page_reg <= op_page_next;
        op_slot_reg <= op_slot_next;
        rsp_reg     <= rsp_next;
    end

`ifndef SYNTHESIS
    a_claimed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        claimed_reg <= PLINK_W'(NUM_PAGES))
        else $error("claimed page count beyond pool");

    a_active_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        active_page_reg <= claimed_reg)
        else $error("active page not claimed");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> {1'b0, fill_i_reg} < fill_n_reg)
        else $error("fill index past slot count");

    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> done_reg && state_reg == S_IDLE)
        else $error("pop gave no result");

    a_free_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FREE |=> done_reg && rsp_reg.status == ST_OK)
        else $error("free gave no success result");
`endif

endmodule
`default_nettype wire

[src/slab_object_allocator_top.sv]
// Slab object allocator: 16 pages of up to 64 fixed-size slots.
// Request channel: drive req (opcode, free_page, free_slot) and raise start;
// the request is taken at a clock edge with start high and busy low.
// Result channel: done is high for exactly one cycle with rsp (status,
// obj_page, obj_slot, page_in_use); the receiver cannot stall and must take it.
// Every request gives exactly one result.
// Sequence: an allocate from the active list or a free reads the memories at
// acceptance, then writes back and raises done (state POP or FREE).
// Taking a partial page first passes through PART and POP_RD; claiming a fresh
// page chains its slots one per cycle in the slot memory (FILL), then POP_RD.
// Out of memory and a free of an unclaimed page answer without a write-back state.
// Throughput: busy drops in the cycle done is high, so the next request can be
// taken then; out of memory and unclaimed frees run at one request per cycle.
// Configuration: cfg_data (slots per fresh page) is written whenever
// cfg_valid is high; cfg_ready is always high. Write it only while idle.
// Reset (rst_n low, asynchronous) empties all lists, claims no page and sets
// 64 slots per page; memories need no clearing pass.
`default_nettype none
module slab_object_allocator_top
    import soa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire req_t             req,
    output logic                  done,
    output rsp_t                  rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic               slot_we;
    logic [ENTRY_W-1:0] slot_waddr;
    logic [LINK_W-1:0]  slot_wdata;
    logic [ENTRY_W-1:0] slot_raddr;
    logic [LINK_W-1:0]  slot_rdata;
    logic               page_we;
    logic [PAGE_W-1:0]  page_waddr;
    page_ent_t          page_wdata;
    logic [PAGE_W-1:0]  page_raddr;
    page_ent_t          page_rdata;

    soa_slot_mem u_slot_mem (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    soa_page_mem u_page_mem (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    soa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata),
        .page_we    (page_we),
        .page_waddr (page_waddr),
        .page_wdata (page_wdata),
        .page_raddr (page_raddr),
        .page_rdata (page_rdata)
    );

endmodule
`default_nettype wire
